// ===== design/latency_compensated_dry_wet_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// Latency-compensated dry/wet mixer: assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LATENCY_COMPENSATED_DRY_WET_MIXER_MACROS_SVH
`define LATENCY_COMPENSATED_DRY_WET_MIXER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LCDWM_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcdwm check failed");
`define LCDWM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcdwm check failed");
`else
`define LCDWM_ASSERT(lbl, ante, cons)
`define LCDWM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/lcdwm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdwm_pkg
// Shared types, widths and helpers of the dry/wet mixer.
// ----------------------------------------------------------------------------
package lcdwm_pkg;

	localparam int MAX_DELAY_FRAMES = 4096;
	localparam int MAX_CHANNELS     = 8;
	localparam int SAMPLE_BITS      = 24;
	localparam int STORE_DEPTH      = MAX_DELAY_FRAMES * MAX_CHANNELS;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int FRAME_W = $clog2(MAX_DELAY_FRAMES);
	localparam int DELAY_W = 13;
	localparam int CC_W    = 4;
	localparam int CH_W    = 3;
	localparam int WET_W   = 16;
	localparam int GAIN_W  = 16;

	localparam int WET_FULL    = 32768;
	localparam int ROUND_SHIFT = 29;
	localparam int DG_W  = SAMPLE_BITS + GAIN_W;
	localparam int PW_W  = SAMPLE_BITS + WET_W + 1;
	localparam int MIX_W = DG_W + WET_W + 1;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_DELAY_FRAMES  = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_WET_MIX       = 2'd2,
		REG_DRY_GAIN      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_DRY = 2'd0,
		MODE_WET = 2'd1,
		MODE_MIX = 2'd2
	} mode_t;

	typedef struct packed {
		logic [DELAY_W-1:0]       delay_frames;
		logic [CC_W-1:0]          channel_count;
		logic [WET_W-1:0]         wet_mix;
		logic signed [GAIN_W-1:0] dry_gain;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] dry_sample;
		logic signed [SAMPLE_BITS-1:0] processed_sample;
		logic                          processed_ok;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mixed_sample;
		logic [CH_W-1:0]               channel;
	} out_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] dry;
		logic signed [SAMPLE_BITS-1:0] proc;
		mode_t                         mode;
		logic                          use_ring;
		logic [ADDR_W-1:0]             addr;
		logic [CH_W-1:0]               ch;
	} job_t;

	function automatic logic [WET_W-1:0] wet_clamp(input logic [WET_W-1:0] w);
		return (w > WET_W'(WET_FULL)) ? WET_W'(WET_FULL) : w;
	endfunction

endpackage

// ===== design/lcdwm_queue.sv =====
// ----------------------------------------------------------------------------
// lcdwm_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module lcdwm_queue import lcdwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== design/lcdwm_front.sv =====
// ----------------------------------------------------------------------------
// lcdwm_front
// Takes requests, tracks channel and ring frame, classifies each sample.
// ----------------------------------------------------------------------------
module lcdwm_front import lcdwm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     hold,
	input  logic     push,
	input  in_item_t din,
	output logic     full,
	output logic     q_push,
	output job_t     q_data,
	input  logic     q_full
);

	logic [CH_W-1:0]    ch_q;
	logic [FRAME_W-1:0] wf_q;

	logic [CC_W-1:0]    cc;
	logic [DELAY_W-1:0] dly;
	logic               wet_full;
	logic [CH_W-1:0]    ch_cur;
	logic [FRAME_W-1:0] wf_cur;
	logic               use_ring;
	logic               last;
	logic [DELAY_W-1:0] wf_inc;
	logic [15:0]        base;
	logic               accept;

	assign full   = q_full || hold;
	assign accept = push && !full;
	assign q_push = accept;

	always_comb begin
		if (cfg.channel_count == '0)
			cc = CC_W'(1);
		else if (cfg.channel_count > CC_W'(MAX_CHANNELS))
			cc = CC_W'(MAX_CHANNELS);
		else
			cc = cfg.channel_count;
		dly      = (cfg.delay_frames > DELAY_W'(MAX_DELAY_FRAMES)) ?
			DELAY_W'(MAX_DELAY_FRAMES) : cfg.delay_frames;
		wet_full = (wet_clamp(cfg.wet_mix) == WET_W'(WET_FULL));
		ch_cur   = (CC_W'(ch_q) >= cc) ? '0 : ch_q;
		wf_cur   = (dly == '0 || DELAY_W'(wf_q) >= dly) ? '0 : wf_q;
		use_ring = (dly != '0) && (!din.processed_ok || !wet_full);
		last     = (CC_W'(ch_cur) + CC_W'(1)) >= cc;
		wf_inc   = DELAY_W'(wf_cur) + DELAY_W'(1);
		base     = 16'(wf_cur) * 16'(cc);

		q_data.dry      = din.dry_sample;
		q_data.proc     = din.processed_sample;
		q_data.use_ring = use_ring;
		q_data.addr     = ADDR_W'(base + 16'(ch_cur));
		q_data.ch       = ch_cur;
		if (!din.processed_ok)
			q_data.mode = MODE_DRY;
		else if (wet_full)
			q_data.mode = MODE_WET;
		else
			q_data.mode = MODE_MIX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			wf_q <= '0;
		end else if (accept) begin
			ch_q <= last ? '0 : ch_cur + CH_W'(1);
			if (last && use_ring)
				wf_q <= (wf_inc >= dly) ? '0 : wf_inc[FRAME_W-1:0];
			else
				wf_q <= wf_cur;
		end
	end

endmodule

// ===== design/lcdwm_back.sv =====
// ----------------------------------------------------------------------------
// lcdwm_back
// Ring store access, gain/wet multiplies, rounding, saturation, result reg.
// Clears the ring store after reset.
// ----------------------------------------------------------------------------
`include "latency_compensated_dry_wet_mixer_macros.svh"

module lcdwm_back import lcdwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	output logic      busy,
	input  logic      q_empty,
	input  job_t      q_data,
	output logic      q_pop,
	output out_item_t dout,
	output logic      empty,
	input  logic      pop
);

	typedef enum logic [3:0] {
		ST_TAKE = 4'b0001,
		ST_MUL1 = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              out_valid_q;
	out_item_t         out_q;

	job_t                          job_q;
	logic [SAMPLE_BITS-1:0]        store_mem [STORE_DEPTH];
	logic [SAMPLE_BITS-1:0]        rdata_q;
	logic signed [SAMPLE_BITS-1:0] delayed_q;
	logic signed [DG_W-1:0]        prod_dg_q;
	logic signed [PW_W-1:0]        prod_pw_q;
	logic signed [MIX_W-1:0]       mix_q;

	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic [SAMPLE_BITS-1:0]        mem_wdata;
	logic [WET_W-1:0]              w;
	logic [WET_W-1:0]              wet_inv;
	logic signed [SAMPLE_BITS-1:0] delayed;
	logic signed [MIX_W-1:0]       sum;
	logic signed [MIX_W-1:0]       shifted;
	logic signed [SAMPLE_BITS-1:0] blend;
	logic signed [SAMPLE_BITS-1:0] result;
	logic                          out_load;

	assign busy    = clearing_q;
	assign w       = wet_clamp(cfg.wet_mix);
	assign wet_inv = WET_W'(WET_FULL) - w;
	assign q_pop   = (state_q == ST_TAKE) && !clearing_q && !q_empty;
	assign delayed = job_q.use_ring ? $signed(rdata_q) : job_q.dry;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign dout    = out_q;

	always_comb begin
		mem_we    = clearing_q || ((state_q == ST_MUL1) && job_q.use_ring);
		mem_waddr = clearing_q ? clr_addr_q : job_q.addr;
		mem_wdata = clearing_q ? '0 : job_q.dry;
	end

	always_comb begin
		sum     = mix_q + ({{(MIX_W-PW_W){prod_pw_q[PW_W-1]}}, prod_pw_q} <<< 14)
			+ (MIX_W'(1) <<< (ROUND_SHIFT - 1));
		shifted = sum >>> ROUND_SHIFT;
		if (shifted > MIX_W'(SAMPLE_MAX))
			blend = SAMPLE_MAX;
		else if (shifted < MIX_W'(SAMPLE_MIN))
			blend = SAMPLE_MIN;
		else
			blend = shifted[SAMPLE_BITS-1:0];
		case (job_q.mode)
			MODE_DRY: result = delayed_q;
			MODE_WET: result = job_q.proc;
			MODE_MIX: result = blend;
			default:  result = delayed_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_waddr] <= mem_wdata;
		rdata_q <= store_mem[q_data.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == '1)
					clearing_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_TAKE: begin
					if (q_pop)
						state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load)
						state_q <= ST_TAKE;
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_data;
		if (state_q == ST_MUL1) begin
			delayed_q <= delayed;
			prod_dg_q <= delayed * cfg.dry_gain;
			prod_pw_q <= job_q.proc * $signed({1'b0, w});
		end
		if (state_q == ST_MUL2)
			mix_q <= prod_dg_q * $signed({1'b0, wet_inv});
		if (out_load) begin
			out_q.mixed_sample <= result;
			out_q.channel      <= job_q.ch;
		end
	end

	`LCDWM_ASSERT(a_no_take_while_clearing, clearing_q, !q_pop)
	`LCDWM_ASSERT_NXT(a_clear_once, !clearing_q, !clearing_q)
	`LCDWM_ASSERT_NXT(a_take_starts_mul, q_pop, state_q == ST_MUL1)
	`LCDWM_ASSERT_NXT(a_done_delivers, (state_q == ST_DONE) && !out_valid_q, out_valid_q)

endmodule

// ===== design/latency_compensated_dry_wet_mixer.sv =====
// ----------------------------------------------------------------------------
// latency_compensated_dry_wet_mixer
// Dry/wet mixer with a ring delay on the dry path to match effect latency.
// ----------------------------------------------------------------------------
// Samples enter interleaved, channel 0 first. The back end takes each sample
// through ring read, gain multiply, wet multiply, round and saturate, and
// starts no new sample before the last result is loaded; a two-entry job
// queue and a result register let either side stall without stopping the
// other. After reset the 32768-entry ring store is cleared one entry per
// cycle, while full stays high; register writes are taken as usual.
module latency_compensated_dry_wet_mixer import lcdwm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [WET_W-1:0]  cfg_wdata,
	input  logic              push,
	input  in_item_t          din,
	output logic              full,
	output out_item_t         dout,
	output logic              empty,
	input  logic              pop
);

	cfg_t cfg_q;
	logic busy;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_frames  <= '0;
			cfg_q.channel_count <= CC_W'(2);
			cfg_q.wet_mix       <= WET_W'(WET_FULL);
			cfg_q.dry_gain      <= GAIN_W'(16384);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY_FRAMES:  cfg_q.delay_frames  <= cfg_wdata[DELAY_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[CC_W-1:0];
				REG_WET_MIX:       cfg_q.wet_mix       <= cfg_wdata;
				REG_DRY_GAIN:      cfg_q.dry_gain      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lcdwm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.hold   (busy),
		.push   (push),
		.din    (din),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	lcdwm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	lcdwm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.busy    (busy),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.dout    (dout),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
